// File: src/rsdz_pkg.sv
`timescale 1ns / 1ps

package rsdz_pkg;

	// Widths fixed by the interface
	localparam int FIELD_W         = 16;
	localparam int ZONE_W          = 17;
	localparam int ZONE_FRAC_W     = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Output full scale in Q1.15 and the quotient widths it implies.
	// Before the rescale an axis reaches (mag-dz)*32767/(full-dz), up to about
	// 13575*32767 when the zone sits one count below full scale: 29 bits.
	localparam int OUT_MAX = 32767;
	localparam int OUT_W   = 15;
	localparam int Q1_W    = 29;
	localparam int Q2_W    = 15;

	localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd4588;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;

	// How an item is finished
	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_INSIDE,
		KIND_ZERO,
		KIND_CALC
	} kind_t;

	// Per-item sideband carried alongside the arithmetic
	typedef struct packed {
		logic                sel;
		kind_t               kind;
		logic [FIELD_W-1:0]  px;
		logic [FIELD_W-1:0]  py;
	} side_t;

endpackage

// File: src/rsdz_front.sv
`timescale 1ns / 1ps

module rsdz_front #(
	parameter int SAMPLE_BITS = rsdz_pkg::SAMPLE_BITS_DEF,
	parameter int W           = $bits(rsdz_pkg::side_t) + 3 * SAMPLE_BITS - 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rsdz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsdz_pkg::ZONE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                stick_select,
	input  logic [rsdz_pkg::FIELD_W-1:0]        raw_x,
	input  logic [rsdz_pkg::FIELD_W-1:0]        raw_y,
	output logic                                f_valid,
	input  logic                                f_ready,
	output logic [W-1:0]                        f_data
);

	localparam int B    = SAMPLE_BITS;
	localparam int DZ_W = B - 1;
	localparam int P_W  = B + rsdz_pkg::ZONE_FRAC_W - 1;
	localparam logic [DZ_W-1:0] FULL = DZ_W'((1 << (B - 1)) - 1);

	logic [rsdz_pkg::ZONE_W-1:0] left_zone_q, right_zone_q, zone;
	logic signed [B-1:0]         xs, ys;
	logic [B-1:0]                ax, ay;
	logic [P_W-1:0]              dz_prod;
	rsdz_pkg::side_t             side;
	logic                        valid_s1;
	logic [W-1:0]                data_s1;

	// Dead-zone registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_zone_q  <= rsdz_pkg::ZONE_RESET;
			right_zone_q <= rsdz_pkg::ZONE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				rsdz_pkg::CFG_LEFT:  left_zone_q  <= cfg_data;
				rsdz_pkg::CFG_RIGHT: right_zone_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the sample and prepare operands
	assign zone = stick_select ? right_zone_q : left_zone_q;
	assign xs   = raw_x[B-1:0];
	assign ys   = raw_y[B-1:0];
	assign ax   = xs[B-1] ? (~raw_x[B-1:0] + B'(1)) : raw_x[B-1:0];
	assign ay   = ys[B-1] ? (~raw_y[B-1:0] + B'(1)) : raw_y[B-1:0];
	assign dz_prod = P_W'(zone[rsdz_pkg::ZONE_FRAC_W-1:0]) * P_W'(FULL);

	always_comb begin
		side.sel = stick_select;
		side.px  = rsdz_pkg::FIELD_W'(xs);
		side.py  = rsdz_pkg::FIELD_W'(ys);
		if (zone == '0) begin
			side.kind = rsdz_pkg::KIND_PASS;
		end else if (zone[rsdz_pkg::ZONE_FRAC_W]) begin
			side.kind = rsdz_pkg::KIND_INSIDE;
		end else begin
			side.kind = rsdz_pkg::KIND_CALC;
		end
	end

	// Input register
	assign in_ready = !valid_s1 || f_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= {side, ax, ay, dz_prod[P_W-1:rsdz_pkg::ZONE_FRAC_W]};
		end
	end

	assign f_valid = valid_s1;
	assign f_data  = data_s1;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !f_ready |=> valid_s1 && $stable(data_s1))
		else $error("front item changed while queue was full");

endmodule

// File: src/rsdz_queue.sv
`timescale 1ns / 1ps

module rsdz_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         pop,
	output logic [W-1:0] out_data
);

	localparam int DEPTH = 2;

	logic [W-1:0] mem_q [0:DEPTH-1];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push, take;

	assign in_ready  = (cnt_q != 2'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign take      = pop && out_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (take) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH))
		else $error("queue count overflow");

endmodule

// File: src/rsdz_isqrt.sv
`timescale 1ns / 1ps

module rsdz_isqrt #(
	parameter int ROOT_W = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2*ROOT_W-1:0]   rad,
	output logic [ROOT_W-1:0]     root
);

	localparam int IN_W = 2 * ROOT_W;

	logic [IN_W-1:0]   rem_q  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_q [0:ROOT_W-1];

	// One root bit per stage, most significant first
	for (genvar k = 0; k < ROOT_W; k++) begin : g_st
		localparam int SH = ROOT_W - 1 - k;
		logic [IN_W-1:0]   r_in;
		logic [ROOT_W-1:0] t_in;
		logic [IN_W:0]     trial;
		logic              take;

		if (k == 0) begin : g_first
			assign r_in = rad;
			assign t_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign t_in = root_q[k-1];
		end

		// (t + 2^SH)^2 - t^2 = t*2^(SH+1) + 4^SH
		assign trial = ((IN_W+1)'(t_in) << (SH + 1)) | ((IN_W+1)'(1) << (2 * SH));
		assign take  = (IN_W+1)'(r_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= take ? (r_in - trial[IN_W-1:0]) : r_in;
				root_q[k] <= take ? (t_in | (ROOT_W'(1) << SH)) : t_in;
			end
		end
	end

	assign root = root_q[ROOT_W-1];

endmodule

// File: src/rsdz_div.sv
`timescale 1ns / 1ps

module rsdz_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16,
	parameter int Q_W   = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [NUM_W-1:0] rem_q [0:Q_W-1];
	logic [DEN_W-1:0] den_q [0:Q_W-1];
	logic [Q_W-1:0]   quo_q [0:Q_W-1];

	// Restoring division, one quotient bit per stage; quotient fits Q_W bits
	for (genvar k = 0; k < Q_W; k++) begin : g_st
		localparam int SH = Q_W - 1 - k;
		logic [NUM_W-1:0] r_in;
		logic [DEN_W-1:0] d_in;
		logic [Q_W-1:0]   q_in;
		logic             take;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
		end

		assign take = (r_in >> SH) >= NUM_W'(d_in);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? (r_in - (NUM_W'(d_in) << SH)) : r_in;
				den_q[k] <= d_in;
				quo_q[k] <= take ? (q_in | (Q_W'(1) << SH)) : q_in;
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

// File: src/rsdz_back.sv
`timescale 1ns / 1ps

module rsdz_back #(
	parameter int SAMPLE_BITS = rsdz_pkg::SAMPLE_BITS_DEF,
	parameter int W           = $bits(rsdz_pkg::side_t) + 3 * SAMPLE_BITS - 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [W-1:0]                  q_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          stick_id,
	output logic [rsdz_pkg::FIELD_W-1:0]  scaled_x,
	output logic [rsdz_pkg::FIELD_W-1:0]  scaled_y,
	output logic                          inside_zone
);

	localparam int B     = SAMPLE_BITS;
	localparam int DZ_W  = B - 1;
	localparam int SQ_W  = 2 * B;
	localparam int DEN_W = 2 * B - 1;
	localparam int K_W   = B + rsdz_pkg::OUT_W;
	localparam int NUM_W = B + K_W;
	localparam int N2_W  = rsdz_pkg::Q1_W + rsdz_pkg::OUT_W;
	localparam int Q1_W  = rsdz_pkg::Q1_W;
	localparam int Q2_W  = rsdz_pkg::Q2_W;
	localparam int P_M   = B + 1;
	localparam int P_N   = B + 2;
	localparam int P_O   = P_N + Q1_W + 1;
	localparam int LAST  = P_O + Q2_W + 1;
	localparam logic [DZ_W-1:0] FULL = DZ_W'((1 << (B - 1)) - 1);
	localparam logic [Q1_W-1:0] OMAX = Q1_W'(rsdz_pkg::OUT_MAX);

	logic                  en;
	logic [LAST:0]         vld_q;
	rsdz_pkg::side_t       side_q [0:LAST-1];
	rsdz_pkg::side_t       side_in, side_m;
	logic [B-1:0]          ax_in, ay_in;
	logic [DZ_W-1:0]       dz_in;
	logic [SQ_W-1:0]       sq_s0;
	logic [B-1:0]          ax_q [0:B];
	logic [B-1:0]          ay_q [0:B];
	logic [DZ_W-1:0]       dz_q [0:B];
	logic [B-1:0]          mag;
	logic [DEN_W-1:0]      den_m, den_n;
	logic [K_W-1:0]        k_m;
	logic [B-1:0]          ax_m, ay_m;
	logic [NUM_W-1:0]      numx_n, numy_n;
	logic [Q1_W-1:0]       tx, ty, m_o;
	logic [Q1_W-1:0]       tx_d [0:Q2_W];
	logic [Q1_W-1:0]       ty_d [0:Q2_W];
	logic                  ovf_d [0:Q2_W];
	logic [N2_W-1:0]       n2x_o, n2y_o;
	logic [Q2_W-1:0]       q2x, q2y;
	logic [rsdz_pkg::OUT_W-1:0] fx, fy;
	rsdz_pkg::side_t       side_f;
	logic [rsdz_pkg::FIELD_W-1:0] ox, oy;
	logic                  oin;
	logic                  stick_id_q, inside_q;
	logic [rsdz_pkg::FIELD_W-1:0] sx_q, sy_q;

	// Whole back pipeline advances unless the output item is stalled
	assign en    = !vld_q[LAST] || out_ready;
	assign q_pop = en && q_valid;

	assign side_in = rsdz_pkg::side_t'(q_data[W-1 -: $bits(rsdz_pkg::side_t)]);
	assign ax_in   = q_data[2*B+DZ_W-1 -: B];
	assign ay_in   = q_data[B+DZ_W-1 -: B];
	assign dz_in   = q_data[DZ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:0], q_valid};
		end
	end

	// Dead-zone decision once the magnitude is known
	always_comb begin
		side_m = side_q[P_M-1];
		if (side_m.kind == rsdz_pkg::KIND_CALC) begin
			if (mag < B'(dz_q[B])) begin
				side_m.kind = rsdz_pkg::KIND_INSIDE;
			end else if (mag == '0) begin
				side_m.kind = rsdz_pkg::KIND_ZERO;
			end
		end
	end

	// Sideband and operand delay lines
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int j = 1; j < LAST; j++) begin
				side_q[j] <= (j == P_M) ? side_m : side_q[j-1];
			end
			sq_s0 <= SQ_W'(ax_in) * SQ_W'(ax_in) + SQ_W'(ay_in) * SQ_W'(ay_in);
			ax_q[0] <= ax_in;
			ay_q[0] <= ay_in;
			dz_q[0] <= dz_in;
			for (int j = 1; j <= B; j++) begin
				ax_q[j] <= ax_q[j-1];
				ay_q[j] <= ay_q[j-1];
				dz_q[j] <= dz_q[j-1];
			end
		end
	end

	rsdz_isqrt #(.ROOT_W(B)) u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sq_s0),
		.root (mag)
	);

	// Denominator mag*(full-dz) and gain (mag-dz)*32767, then the numerators
	always_ff @(posedge clk) begin
		if (en) begin
			den_m  <= DEN_W'(mag) * DEN_W'(FULL - dz_q[B]);
			k_m    <= K_W'(mag - B'(dz_q[B])) * K_W'(rsdz_pkg::OUT_MAX);
			ax_m   <= ax_q[B];
			ay_m   <= ay_q[B];
			numx_n <= NUM_W'(ax_m) * NUM_W'(k_m);
			numy_n <= NUM_W'(ay_m) * NUM_W'(k_m);
			den_n  <= den_m;
		end
	end

	rsdz_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q1_W)) u_div_x (
		.clk (clk), .en (en), .num (numx_n), .den (den_n), .quo (tx)
	);
	rsdz_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q1_W)) u_div_y (
		.clk (clk), .en (en), .num (numy_n), .den (den_n), .quo (ty)
	);

	// Overflow check and operands of the rescale by the larger axis
	always_ff @(posedge clk) begin
		if (en) begin
			tx_d[0]  <= tx;
			ty_d[0]  <= ty;
			ovf_d[0] <= (tx > OMAX) || (ty > OMAX);
			m_o      <= (tx > ty) ? tx : ty;
			n2x_o    <= N2_W'(tx) * N2_W'(rsdz_pkg::OUT_MAX);
			n2y_o    <= N2_W'(ty) * N2_W'(rsdz_pkg::OUT_MAX);
			for (int j = 1; j <= Q2_W; j++) begin
				tx_d[j]  <= tx_d[j-1];
				ty_d[j]  <= ty_d[j-1];
				ovf_d[j] <= ovf_d[j-1];
			end
		end
	end

	rsdz_div #(.NUM_W(N2_W), .DEN_W(Q1_W), .Q_W(Q2_W)) u_div2_x (
		.clk (clk), .en (en), .num (n2x_o), .den (m_o), .quo (q2x)
	);
	rsdz_div #(.NUM_W(N2_W), .DEN_W(Q1_W), .Q_W(Q2_W)) u_div2_y (
		.clk (clk), .en (en), .num (n2y_o), .den (m_o), .quo (q2y)
	);

	// Final selection and sign
	assign side_f = side_q[LAST-1];
	assign fx = ovf_d[Q2_W] ? q2x : tx_d[Q2_W][rsdz_pkg::OUT_W-1:0];
	assign fy = ovf_d[Q2_W] ? q2y : ty_d[Q2_W][rsdz_pkg::OUT_W-1:0];

	always_comb begin
		ox  = '0;
		oy  = '0;
		oin = 1'b0;
		case (side_f.kind)
			rsdz_pkg::KIND_PASS: begin
				ox = side_f.px;
				oy = side_f.py;
			end
			rsdz_pkg::KIND_INSIDE: oin = 1'b1;
			rsdz_pkg::KIND_CALC: begin
				ox = side_f.px[rsdz_pkg::FIELD_W-1] ? -rsdz_pkg::FIELD_W'(fx)
					: rsdz_pkg::FIELD_W'(fx);
				oy = side_f.py[rsdz_pkg::FIELD_W-1] ? -rsdz_pkg::FIELD_W'(fy)
					: rsdz_pkg::FIELD_W'(fy);
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			stick_id_q <= side_f.sel;
			sx_q       <= ox;
			sy_q       <= oy;
			inside_q   <= oin;
		end
	end

	assign out_valid   = vld_q[LAST];
	assign stick_id    = stick_id_q;
	assign scaled_x    = sx_q;
	assign scaled_y    = sy_q;
	assign inside_zone = inside_q;

	a_zone_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_zone |-> scaled_x == '0 && scaled_y == '0)
		else $error("item inside the dead zone has nonzero output");

	a_zero_kind: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAST-1] && en && side_f.kind == rsdz_pkg::KIND_ZERO
		|=> scaled_x == '0 && scaled_y == '0 && !inside_zone)
		else $error("zero-magnitude item gave nonzero output");

	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAST-1] && side_f.kind == rsdz_pkg::KIND_CALC && ovf_d[Q2_W]
		|-> m_o >= '0 && (fx == rsdz_pkg::OUT_W'(rsdz_pkg::OUT_MAX)
		|| fy == rsdz_pkg::OUT_W'(rsdz_pkg::OUT_MAX)))
		else $error("rescale left no axis at full scale");

endmodule

// File: src/radial_scaled_dead_zone_top.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while out_ready holds; the root and all four dividers are fully
// pipelined, one result bit per stage, so each stage takes a new item every cycle unless stalled.
// A two-entry queue separates the input register from the arithmetic pipeline.
// Reset (arst_n low, asynchronous): pipeline and queue empty, both dead zones 4588.

module radial_scaled_dead_zone_top #(
	parameter int SAMPLE_BITS = rsdz_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rsdz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsdz_pkg::ZONE_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              stick_select,
	input  logic [rsdz_pkg::FIELD_W-1:0]      raw_x,
	input  logic [rsdz_pkg::FIELD_W-1:0]      raw_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              stick_id,
	output logic [rsdz_pkg::FIELD_W-1:0]      scaled_x,
	output logic [rsdz_pkg::FIELD_W-1:0]      scaled_y,
	output logic                              inside_zone
);

	localparam int QW = $bits(rsdz_pkg::side_t) + 3 * SAMPLE_BITS - 1;

	logic          f_valid, f_ready, q_valid, q_pop;
	logic [QW-1:0] f_data, q_data;

	rsdz_front #(.SAMPLE_BITS(SAMPLE_BITS), .W(QW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.stick_select (stick_select),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.f_valid      (f_valid),
		.f_ready      (f_ready),
		.f_data       (f_data)
	);

	rsdz_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (q_valid),
		.pop       (q_pop),
		.out_data  (q_data)
	);

	rsdz_back #(.SAMPLE_BITS(SAMPLE_BITS), .W(QW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stick_id    (stick_id),
		.scaled_x    (scaled_x),
		.scaled_y    (scaled_y),
		.inside_zone (inside_zone)
	);

endmodule
